// ===== hw/rtl/gpc_pkg.sv =====
package gpc_pkg;

  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic [35:0] MZ_LIMIT     = 36'd2097152000;
  localparam logic [33:0] OFFSET_CAP   = 34'h2_0000_0000;
  localparam logic [19:0] RES_RESET    = 20'd60000;
  localparam logic [31:0] WIDTH_SQ_DIV = 32'd400;
  localparam logic [3:0]  EXP_TERMS    = 4'd12;
  localparam logic [4:0]  LOG_FRAC_TOP = 5'd25;
  localparam logic [6:0]  DIV_TOP_FULL = 7'd127;
  localparam logic [6:0]  DIV_TOP_EXP  = 7'd30;

  typedef struct packed {
    logic [31:0] point_mz;
    logic [31:0] point_intensity;
    logic        end_of_spectrum;
  } point_t;

  typedef struct packed {
    logic [30:0] centroid_mz;
    logic [31:0] centroid_intensity;
    logic        fit_rejected;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [31:0] am;
    logic [31:0] ai;
    logic [31:0] bm;
    logic [31:0] bi;
  } fit_req_t;

  typedef struct packed {
    logic    idle;
    logic    valid;
    result_t data;
  } fit_rsp_t;

  typedef struct packed {
    logic         start;
    logic [127:0] num;
    logic [63:0]  den;
    logic [6:0]   top;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

endpackage

// ===== hw/rtl/gpc_div.sv =====
module gpc_div (
  input  logic             clk,
  input  logic             rst,
  input  gpc_pkg::div_req_t req,
  output gpc_pkg::div_rsp_t rsp
);

  logic [127:0] nsr;
  logic [63:0]  den;
  logic [63:0]  rem;
  logic [63:0]  quot;
  logic [6:0]   idx;
  logic         busy;
  logic         done;
  logic         sat;

  logic [64:0] remx;
  logic        ge;
  logic [64:0] diff;

  // restoring step, one quotient bit a cycle
  always_comb begin
    remx = {rem, nsr[127]};
    ge   = remx >= {1'b0, den};
    diff = remx - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        nsr  <= req.num;
        den  <= req.den;
        idx  <= req.top;
        rem  <= '0;
        quot <= '0;
        sat  <= 1'b0;
      end else if (busy) begin
        nsr  <= {nsr[126:0], 1'b0};
        rem  <= ge ? diff[63:0] : remx[63:0];
        quot <= {quot[62:0], ge};
        if (ge && idx[6]) begin
          sat <= 1'b1;
        end
        if (idx == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx - 7'd1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = (sat || den == 64'd0) ? {64{1'b1}} : quot;

endmodule

// ===== hw/rtl/gpc_fit.sv =====
module gpc_fit (
  input  logic              clk,
  input  logic              rst,
  input  gpc_pkg::fit_req_t  req,
  input  logic [19:0]       resolution,
  input  logic              take,
  output gpc_pkg::fit_rsp_t  rsp,
  output gpc_pkg::div_req_t  dreq,
  input  gpc_pkg::div_rsp_t  drsp
);

  typedef enum logic [28:0] {
    S_IDLE   = 29'h0000_0001,
    S_LOGMUL = 29'h0000_0002,
    S_LOGUPD = 29'h0000_0004,
    S_LNMUL  = 29'h0000_0008,
    S_WAA    = 29'h0000_0010,
    S_WLO    = 29'h0000_0020,
    S_WHI    = 29'h0000_0040,
    S_WR1    = 29'h0000_0080,
    S_WR2    = 29'h0000_0100,
    S_WDIV   = 29'h0000_0200,
    S_WWAIT  = 29'h0000_0400,
    S_OD     = 29'h0000_0800,
    S_OLO    = 29'h0000_1000,
    S_OHI    = 29'h0000_2000,
    S_ODIV   = 29'h0000_4000,
    S_OWAIT  = 29'h0000_8000,
    S_CCALC  = 29'h0001_0000,
    S_CCHK   = 29'h0002_0000,
    S_ELO    = 29'h0004_0000,
    S_EHI    = 29'h0008_0000,
    S_EDIV   = 29'h0010_0000,
    S_EWAIT  = 29'h0020_0000,
    S_XCHK   = 29'h0040_0000,
    S_XMUL   = 29'h0080_0000,
    S_XDIV   = 29'h0100_0000,
    S_XWAIT  = 29'h0200_0000,
    S_XTEST  = 29'h0400_0000,
    S_FRND   = 29'h0800_0000,
    S_DONE   = 29'h1000_0000
  } state_t;

  state_t state;

  logic [31:0]  am, ai, bm, bi;
  logic [31:0]  y;
  logic [25:0]  f;
  logic [4:0]   k;
  logic [4:0]   cnt;
  logic         log_b;
  logic [30:0]  la, lb;
  logic [31:0]  ln;
  logic [31:0]  mz_gap;
  logic [63:0]  ta;
  logic [95:0]  tb;
  logic [63:0]  w2;
  logic [33:0]  off;
  logic [30:0]  c;
  logic [31:0]  e;
  logic [63:0]  e34;
  logic [32:0]  sum;
  logic [30:0]  term;
  logic [3:0]   n;
  logic [31:0]  fit_int;
  logic         rej;
  logic [63:0]  mp;

  logic [31:0]  mul_a, mul_b;
  logic [19:0]  res_eff;
  logic [32:0]  sq;
  logic [31:0]  y_upd;
  logic [25:0]  f_upd;
  logic [95:0]  wide_sum;
  logic [32:0]  mid;
  logic [35:0]  cs;
  logic [31:0]  e_val;
  logic [36:0]  sum9;
  logic [64:0]  rnd;
  logic [36:0]  nrm_a, nrm_b;

  // leading-one normalize: {msb index, value shifted so the msb sits at bit 31}
  function automatic logic [36:0] norm(input logic [31:0] x);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        p = 5'(i);
      end
    end
    return {p, x << (5'd31 - p)};
  endfunction

  always_comb begin
    res_eff  = (resolution == 20'd0) ? 20'd1 : resolution;
    sq       = mp[63:31];
    y_upd    = sq[32] ? sq[32:1] : sq[31:0];
    f_upd    = f;
    f_upd[cnt] = sq[32];
    wide_sum = {mp, 32'h0} + tb;
    mid      = ({1'b0, am} + {1'b0, bm}) >> 1;
    cs       = (am > bm) ? ({3'b0, mid} + {2'b0, off}) : ({3'b0, mid} - {2'b0, off});
    e_val    = ({4'b0, am} >= cs) ? (am - cs[31:0]) : (cs[31:0] - am);
    sum9     = {4'b0, sum} * 37'd9;
    rnd      = {1'b0, mp} + 65'h2000_0000;
    nrm_a    = norm(req.ai);
    nrm_b    = norm(bi);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_LOGMUL: begin mul_a = y; mul_b = y; end
      S_LNMUL: begin
        mul_a = (la > lb) ? {1'b0, la - lb} : 32'd0;
        mul_b = gpc_pkg::LN2_Q32;
      end
      S_WAA:  begin mul_a = am; mul_b = am; end
      S_WLO:  begin mul_a = mp[31:0]; mul_b = am; end
      S_WHI:  begin mul_a = ta[63:32]; mul_b = am; end
      S_WR1:  begin mul_a = gpc_pkg::WIDTH_SQ_DIV; mul_b = {12'b0, res_eff}; end
      S_WR2:  begin mul_a = mp[31:0]; mul_b = {12'b0, res_eff}; end
      S_OD:   begin mul_a = gpc_pkg::LN2_Q32; mul_b = mz_gap; end
      S_OLO:  begin mul_a = w2[31:0]; mul_b = ln; end
      S_OHI:  begin mul_a = w2[63:32]; mul_b = ln; end
      S_CCHK: begin mul_a = e; mul_b = e; end
      S_ELO:  begin mul_a = gpc_pkg::LN2_Q32; mul_b = mp[31:0]; end
      S_EHI:  begin mul_a = gpc_pkg::LN2_Q32; mul_b = ta[63:32]; end
      S_XMUL: begin mul_a = {1'b0, term}; mul_b = {2'b0, e34[33:4]}; end
      S_XTEST: begin mul_a = ai; mul_b = sum[31:0]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // shared divider requests
  always_comb begin
    dreq = '0;
    case (state)
      S_WDIV: begin
        dreq.start = 1'b1;
        dreq.num   = {56'b0, tb[95:24]};
        dreq.den   = {15'b0, mp[48:0]};
        dreq.top   = gpc_pkg::DIV_TOP_FULL;
      end
      S_ODIV: begin
        dreq.start = 1'b1;
        dreq.num   = {24'b0, wide_sum, 8'b0};
        dreq.den   = ta;
        dreq.top   = gpc_pkg::DIV_TOP_FULL;
      end
      S_EDIV: begin
        dreq.start = 1'b1;
        dreq.num   = {32'b0, wide_sum};
        dreq.den   = w2;
        dreq.top   = gpc_pkg::DIV_TOP_FULL;
      end
      S_XDIV: begin
        dreq.start = 1'b1;
        dreq.num   = {mp[60:30], 97'b0};
        dreq.den   = {60'b0, n};
        dreq.top   = gpc_pkg::DIV_TOP_EXP;
      end
      default: dreq = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    mp <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.start) begin
            am    <= req.am;
            ai    <= req.ai;
            bm    <= req.bm;
            bi    <= req.bi;
            k     <= nrm_a[36:32];
            y     <= nrm_a[31:0];
            f     <= '0;
            cnt   <= gpc_pkg::LOG_FRAC_TOP;
            log_b <= 1'b0;
            state <= S_LOGMUL;
          end
        end
        S_LOGMUL: state <= S_LOGUPD;
        S_LOGUPD: begin
          y <= y_upd;
          f <= f_upd;
          if (cnt != 5'd0) begin
            cnt   <= cnt - 5'd1;
            state <= S_LOGMUL;
          end else if (!log_b) begin
            la    <= {k, f_upd};
            k     <= nrm_b[36:32];
            y     <= nrm_b[31:0];
            f     <= '0;
            cnt   <= gpc_pkg::LOG_FRAC_TOP;
            log_b <= 1'b1;
            state <= S_LOGMUL;
          end else begin
            lb    <= {k, f_upd};
            state <= S_LNMUL;
          end
        end
        S_LNMUL: state <= S_WAA;
        S_WAA: begin
          ln     <= mp[63:32];
          mz_gap <= (am > bm) ? (am - bm) : (bm - am);
          state  <= S_WLO;
        end
        S_WLO: begin
          ta    <= mp;
          state <= S_WHI;
        end
        S_WHI: begin
          tb    <= {32'b0, mp};
          state <= S_WR1;
        end
        S_WR1: begin
          tb    <= wide_sum;
          state <= S_WR2;
        end
        S_WR2: state <= S_WDIV;
        S_WDIV: state <= S_WWAIT;
        S_WWAIT: begin
          if (drsp.done) begin
            w2 <= drsp.quot;
            if (mz_gap != 32'd0) begin
              state <= S_OD;
            end else begin
              off   <= '0;
              state <= S_CCALC;
            end
          end
        end
        S_OD: state <= S_OLO;
        S_OLO: begin
          ta    <= mp;
          state <= S_OHI;
        end
        S_OHI: begin
          tb    <= {32'b0, mp};
          state <= S_ODIV;
        end
        S_ODIV: state <= S_OWAIT;
        S_OWAIT: begin
          if (drsp.done) begin
            off   <= (drsp.quot > {30'b0, gpc_pkg::OFFSET_CAP}) ? gpc_pkg::OFFSET_CAP
                                                                 : drsp.quot[33:0];
            state <= S_CCALC;
          end
        end
        S_CCALC: begin
          // centre off the allowed m/z range: no result
          if (cs[35] || cs > gpc_pkg::MZ_LIMIT) begin
            state <= S_IDLE;
          end else begin
            c     <= cs[30:0];
            e     <= e_val;
            state <= S_CCHK;
          end
        end
        S_CCHK: begin
          if (e == 32'd0) begin
            e34   <= '0;
            state <= S_XCHK;
          end else if (w2 == 64'd0) begin
            fit_int <= ai;
            rej     <= 1'b1;
            state   <= S_DONE;
          end else begin
            state <= S_ELO;
          end
        end
        S_ELO: begin
          ta    <= mp;
          state <= S_EHI;
        end
        S_EHI: begin
          tb    <= {32'b0, mp};
          state <= S_EDIV;
        end
        S_EDIV: state <= S_EWAIT;
        S_EWAIT: begin
          if (drsp.done) begin
            e34   <= drsp.quot;
            state <= S_XCHK;
          end
        end
        S_XCHK: begin
          if (e34[63:34] != 30'd0) begin
            fit_int <= ai;
            rej     <= 1'b1;
            state   <= S_DONE;
          end else begin
            sum   <= 33'h0_4000_0000;
            term  <= 31'h4000_0000;
            n     <= 4'd1;
            state <= S_XMUL;
          end
        end
        S_XMUL: state <= S_XDIV;
        S_XDIV: state <= S_XWAIT;
        S_XWAIT: begin
          if (drsp.done) begin
            term <= drsp.quot[30:0];
            sum  <= sum + {2'b0, drsp.quot[30:0]};
            if (n == gpc_pkg::EXP_TERMS) begin
              state <= S_XTEST;
            end else begin
              n     <= n + 4'd1;
              state <= S_XMUL;
            end
          end
        end
        S_XTEST: begin
          // deviation above ten percent keeps the measured apex
          if (sum9 <= 37'h2_8000_0000) begin
            state <= S_FRND;
          end else begin
            fit_int <= ai;
            rej     <= 1'b1;
            state   <= S_DONE;
          end
        end
        S_FRND: begin
          fit_int <= (rnd[64:62] != 3'd0) ? 32'hFFFF_FFFF : rnd[61:30];
          rej     <= 1'b0;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.idle = (state == S_IDLE);
  assign rsp.valid = (state == S_DONE);
  assign rsp.data.centroid_mz = c;
  assign rsp.data.centroid_intensity = fit_int;
  assign rsp.data.fit_rejected = rej;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == S_IDLE)
    else $error("fit start while busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> (state == S_WWAIT || state == S_OWAIT ||
                   state == S_EWAIT || state == S_XWAIT))
    else $error("divider result outside a wait state");

  a_term_range: assert property (@(posedge clk) disable iff (rst)
    state == S_XWAIT |-> (n >= 4'd1 && n <= gpc_pkg::EXP_TERMS))
    else $error("series term index out of range");

  a_take_done: assert property (@(posedge clk) disable iff (rst)
    (take && state == S_DONE) |=> state == S_IDLE)
    else $error("result transfer did not free the fit unit");

endmodule

// ===== hw/rtl/gaussian_peak_centroider_top.sv =====
// a point that is no peak is absorbed at its transfer; a peak's result is computed after the
//   transfer that revealed it by two 26-step log2 runs, up to three 128-step divisions and up to
//   twelve 31-step divisions on one shared divider and multiplier
// in_ready stays low until the fit unit is idle again, so one peak is fitted at a time
// reset: rst synchronous active high; stored points, rising flag and points count clear,
//   resolution returns to 60000, the output register empties
module gaussian_peak_centroider_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  gpc_pkg::point_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output gpc_pkg::result_t out_data,
  input  logic             cfg_we,
  input  logic [19:0]      cfg_wdata
);

  // spectrum window: previous point and the one before it
  logic [31:0] older_mz, older_intensity;
  logic [31:0] newer_mz, newer_intensity;
  logic [1:0]  points_seen;
  logic        rising;
  logic [19:0] resolution;

  gpc_pkg::fit_req_t fit_req;
  gpc_pkg::fit_rsp_t fit_rsp;
  gpc_pkg::div_req_t div_req;
  gpc_pkg::div_rsp_t div_rsp;

  logic in_xfer;
  logic up;
  logic peak;
  logic older_wins;
  logic take;

  // new points are taken only while the fit unit is free
  assign in_ready = fit_rsp.idle;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    // current point rose above the previous one
    up         = (points_seen != 2'd0) && (newer_intensity < in_data.point_intensity);
    // previous point rose and is not exceeded by the current one: it is the apex
    peak       = !up && rising && (points_seen == 2'd2);
    // partner is the larger neighbour, ties go to the current point
    older_wins = older_intensity > in_data.point_intensity;

    fit_req.am = newer_mz;
    fit_req.ai = newer_intensity;
    fit_req.bm = older_wins ? older_mz : in_data.point_mz;
    fit_req.bi = older_wins ? older_intensity : in_data.point_intensity;
    // a zero partner intensity gives no result, so no fit is started
    fit_req.start = in_xfer && peak && (fit_req.bi != 32'd0);
  end

  // finished result moves into the output register when it is empty or draining
  assign take = fit_rsp.valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      older_mz        <= '0;
      older_intensity <= '0;
      newer_mz        <= '0;
      newer_intensity <= '0;
      points_seen     <= '0;
      rising          <= 1'b0;
      resolution      <= gpc_pkg::RES_RESET;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        resolution <= cfg_wdata;
      end
      if (in_xfer) begin
        if (in_data.end_of_spectrum) begin
          // last point of a spectrum is never an apex; window clears after it
          older_mz        <= '0;
          older_intensity <= '0;
          newer_mz        <= '0;
          newer_intensity <= '0;
          points_seen     <= '0;
          rising          <= 1'b0;
        end else begin
          older_mz        <= newer_mz;
          older_intensity <= newer_intensity;
          newer_mz        <= in_data.point_mz;
          newer_intensity <= in_data.point_intensity;
          if (points_seen != 2'd2) begin
            points_seen <= points_seen + 2'd1;
          end
          rising <= up;
        end
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload register, loaded on each transfer from the fit unit
  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= fit_rsp.data;
    end
  end

  // sequencer, shared multiplier and log2/exp/fit datapath
  gpc_fit u_fit (
    .clk        (clk),
    .rst        (rst),
    .req        (fit_req),
    .resolution (resolution),
    .take       (take),
    .rsp        (fit_rsp),
    .dreq       (div_req),
    .drsp       (div_rsp)
  );

  // shared bit-serial divider
  gpc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule
